// File: rtl/bpma_pkg.sv
// shared constants and types for the blood pressure median and average filter
package bpma_pkg;

  localparam int DATA_W = 8;
  localparam int SUM_W  = 10;
  localparam int CFG_IDX_W = 2;

  // weighted sum 2 x diastolic + systolic
  localparam int WSUM_W = DATA_W + 2;

  // divide by three as multiply by 683 then shift right by 11, exact below 2048
  localparam int DIV3_SHIFT = 11;
  localparam logic [WSUM_W-1:0] DIV3_MUL = WSUM_W'(683);
  localparam int PROD_W = 2 * WSUM_W;

  localparam int AVG_SHIFT = 2;

  typedef logic [DATA_W-1:0] sample_t;
  typedef logic [1:0]        fill_t;
  typedef logic [1:0]        mcount_t;

  // last window slot and last median of a group of four
  localparam fill_t   FILL_LAST   = 2'd2;
  localparam mcount_t MEDIAN_LAST = 2'd3;

  localparam sample_t SYS_LOW_RST  = 8'd100;
  localparam sample_t SYS_HIGH_RST = 8'd140;
  localparam sample_t DIA_LOW_RST  = 8'd70;
  localparam sample_t DIA_HIGH_RST = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYS_LOW  = 2'd0,
    REG_SYS_HIGH = 2'd1,
    REG_DIA_LOW  = 2'd2,
    REG_DIA_HIGH = 2'd3
  } cfg_reg_e;

endpackage

// File: rtl/bpma_chan.sv
// one pressure channel: range gate, median of three, average of four medians
module bpma_chan (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  bpma_pkg::sample_t sample_i,
  input  bpma_pkg::sample_t low_i,
  input  bpma_pkg::sample_t high_i,
  output bpma_pkg::sample_t average_o
);

  function automatic bpma_pkg::sample_t median3(input bpma_pkg::sample_t a,
                                                input bpma_pkg::sample_t b,
                                                input bpma_pkg::sample_t c);
    bpma_pkg::sample_t lo;
    bpma_pkg::sample_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      return lo;
    end else if (c >= hi) begin
      return hi;
    end else begin
      return c;
    end
  endfunction

  // third reading of a group goes straight into the median, so two slots suffice
  bpma_pkg::sample_t                 win_q [2];
  bpma_pkg::fill_t                   fill_q, fill_d;
  bpma_pkg::mcount_t                 cnt_q, cnt_d;
  logic [bpma_pkg::SUM_W-1:0]        sum_q, sum_d;
  bpma_pkg::sample_t                 avg_q, avg_d;

  logic                              take;
  bpma_pkg::sample_t                 med;
  logic [bpma_pkg::SUM_W-1:0]        sum_add;

  assign take    = push_i && (sample_i >= low_i) && (sample_i <= high_i);
  assign med     = median3(win_q[0], win_q[1], sample_i);
  assign sum_add = sum_q + bpma_pkg::SUM_W'(med);

  always_comb begin
    fill_d = fill_q;
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    avg_d  = avg_q;
    if (take) begin
      if (fill_q == bpma_pkg::FILL_LAST) begin
        fill_d = '0;
        if (cnt_q == bpma_pkg::MEDIAN_LAST) begin
          avg_d = bpma_pkg::DATA_W'(sum_add >> bpma_pkg::AVG_SHIFT);
          sum_d = '0;
          cnt_d = '0;
        end else begin
          sum_d = sum_add;
          cnt_d = cnt_q + 2'd1;
        end
      end else begin
        fill_d = fill_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      avg_q  <= '0;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      avg_q  <= avg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && (fill_q != bpma_pkg::FILL_LAST)) begin
      win_q[fill_q[0]] <= sample_i;
    end
  end

  assign average_o = avg_q;

endmodule

// File: rtl/blood_pressure_median_average.sv
// top level of the blood pressure median and average filter
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  in       | in_valid_i / in_stall_o      | systolic_in, diastolic_in, pulse_rate,
//           |                              | oxygen_saturation
//  out      | out_valid_o / out_stall_i    | mean_pressure, systolic_average,
//           |                              | diastolic_average
//  cfg      | cfg_we_i, cfg_idx_i          | cfg_data_i (range bounds)
//
// one item per cycle while the output is not stalled
// channel state updates on acceptance, then the result register takes the mean (one multiplier)
// reset loads the default range bounds and clears all channel counters and averages
// in_stall_o rises only when both the state stage and the result register are full
module blood_pressure_median_average (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [bpma_pkg::DATA_W-1:0]        systolic_in_i,
  input  logic [bpma_pkg::DATA_W-1:0]        diastolic_in_i,
  input  logic [bpma_pkg::DATA_W-1:0]        pulse_rate_i,
  input  logic [bpma_pkg::DATA_W-1:0]        oxygen_saturation_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bpma_pkg::DATA_W-1:0]        mean_pressure_o,
  output logic [bpma_pkg::DATA_W-1:0]        systolic_average_o,
  output logic [bpma_pkg::DATA_W-1:0]        diastolic_average_o,
  input  logic                               cfg_we_i,
  input  logic [bpma_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bpma_pkg::DATA_W-1:0]        cfg_data_i
);

  bpma_pkg::sample_t sys_low_q, sys_high_q, dia_low_q, dia_high_q;

  logic              st_valid_q;
  logic              nosubj_q;
  logic              out_valid_q;
  bpma_pkg::sample_t mean_q, sys_avg_q, dia_avg_q;

  logic              in_take;
  logic              out_free;
  logic              st_free;
  bpma_pkg::sample_t sys_avg, dia_avg;

  logic [bpma_pkg::WSUM_W-1:0] wsum;
  logic [bpma_pkg::PROD_W-1:0] prod;
  bpma_pkg::sample_t           mean_d;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign st_free    = !st_valid_q || out_free;
  assign in_stall_o = !st_free;
  assign in_take    = in_valid_i && st_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_low_q  <= bpma_pkg::SYS_LOW_RST;
      sys_high_q <= bpma_pkg::SYS_HIGH_RST;
      dia_low_q  <= bpma_pkg::DIA_LOW_RST;
      dia_high_q <= bpma_pkg::DIA_HIGH_RST;
    end else if (cfg_we_i) begin
      case (bpma_pkg::cfg_reg_e'(cfg_idx_i))
        bpma_pkg::REG_SYS_LOW:  sys_low_q  <= cfg_data_i;
        bpma_pkg::REG_SYS_HIGH: sys_high_q <= cfg_data_i;
        bpma_pkg::REG_DIA_LOW:  dia_low_q  <= cfg_data_i;
        bpma_pkg::REG_DIA_HIGH: dia_high_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // channel averages double as the payload of the state stage
  bpma_chan u_sys (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_take),
    .sample_i  (systolic_in_i),
    .low_i     (sys_low_q),
    .high_i    (sys_high_q),
    .average_o (sys_avg)
  );

  bpma_chan u_dia (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (in_take),
    .sample_i  (diastolic_in_i),
    .low_i     (dia_low_q),
    .high_i    (dia_high_q),
    .average_o (dia_avg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (st_free) begin
      st_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      nosubj_q <= (pulse_rate_i == '0) && (oxygen_saturation_i == '0);
    end
  end

  assign wsum   = {1'b0, dia_avg, 1'b0} + bpma_pkg::WSUM_W'(sys_avg);
  assign prod   = bpma_pkg::PROD_W'(wsum) * bpma_pkg::PROD_W'(bpma_pkg::DIV3_MUL);
  assign mean_d = nosubj_q ? '0 : prod[bpma_pkg::DIV3_SHIFT +: bpma_pkg::DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= st_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && st_valid_q) begin
      mean_q    <= mean_d;
      sys_avg_q <= sys_avg;
      dia_avg_q <= dia_avg;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign mean_pressure_o     = mean_q;
  assign systolic_average_o  = sys_avg_q;
  assign diastolic_average_o = dia_avg_q;

endmodule

// File: rtl/bpma_checker.sv
// port level checks for the blood pressure median and average filter
module bpma_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bpma_pkg::DATA_W-1:0] mean_pressure_o,
  input logic [bpma_pkg::DATA_W-1:0] systolic_average_o,
  input logic [bpma_pkg::DATA_W-1:0] diastolic_average_o
);

  // a weighted mean never exceeds the larger average
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_pressure_o <= systolic_average_o ||
                     mean_pressure_o <= diastolic_average_o))
    else $error("mean above both averages");

  // and unless forced to zero never drops below the smaller one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mean_pressure_o == '0 ||
                     mean_pressure_o >= systolic_average_o ||
                     mean_pressure_o >= diastolic_average_o))
    else $error("mean below both averages");

  // input backs up only behind a full result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with result register empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(mean_pressure_o) &&
      $stable(systolic_average_o) && $stable(diastolic_average_o))
    else $error("stalled result changed");

endmodule

bind blood_pressure_median_average bpma_checker u_bpma_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_stall_o          (in_stall_o),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .mean_pressure_o     (mean_pressure_o),
  .systolic_average_o  (systolic_average_o),
  .diastolic_average_o (diastolic_average_o)
);

// File: test/blood_pressure_median_average_tb.sv
// self-checking testbench for the blood pressure median and average filter
`timescale 1ns / 100ps

module blood_pressure_median_average_tb;
  import bpma_pkg::*;

  localparam int CH_SYS = 0;
  localparam int CH_DIA = 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 92;
  localparam int NUM_PHASES = 6;

  typedef struct {
    sample_t sys;
    sample_t dia;
    sample_t hr;
    sample_t spo2;
  } reading_t;

  typedef struct {
    sample_t mean;
    sample_t sys_avg;
    sample_t dia_avg;
  } vitals_t;

  typedef struct {
    sample_t          win [3];
    fill_t            fill;
    mcount_t          mcount;
    logic [SUM_W-1:0] sum;
    sample_t          avg;
  } chan_state_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sample_t  sys_in = '0;
  sample_t  dia_in = '0;
  sample_t  hr_in = '0;
  sample_t  spo2_in = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sample_t  mean_out;
  sample_t  sys_avg_out;
  sample_t  dia_avg_out;
  logic     cfg_we = 1'b0;
  cfg_reg_e cfg_idx = REG_SYS_LOW;
  sample_t  cfg_data = '0;

  // predictor state and shadow of the range registers
  chan_state_t chan_st [2];
  sample_t     lim_lo [2];
  sample_t     lim_hi [2];

  reading_t pending [$];
  vitals_t  vitals_due [$];
  reading_t cur_item;
  int       gap_left = 0;
  int       stall_left = 0;
  bit       calm = 1'b0;

  int cycles = 0;
  int errors = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_rejected = 0;
  int n_averages = 0;
  int n_no_subject = 0;

  blood_pressure_median_average u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .systolic_in_i      (sys_in),
    .diastolic_in_i     (dia_in),
    .pulse_rate_i       (hr_in),
    .oxygen_saturation_i(spo2_in),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .mean_pressure_o    (mean_out),
    .systolic_average_o (sys_avg_out),
    .diastolic_average_o(dia_avg_out),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_data_i         (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, vitals_due.size());
      $display("blood_pressure_median_average regression: fail");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one, none while calm
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t median_of_three(sample_t a, sample_t b, sample_t c);
    sample_t lo_v;
    sample_t hi_v;
    lo_v = (a < b) ? a : b;
    hi_v = (a < b) ? b : a;
    if (c <= lo_v) return lo_v;
    if (c >= hi_v) return hi_v;
    return c;
  endfunction

  function automatic void feed_channel(int ch, sample_t x);
    sample_t med;
    if (x < lim_lo[ch] || x > lim_hi[ch]) begin
      n_rejected++;
      return;
    end
    chan_st[ch].win[chan_st[ch].fill] = x;
    if (chan_st[ch].fill == FILL_LAST) begin
      chan_st[ch].fill = '0;
      med = median_of_three(chan_st[ch].win[0], chan_st[ch].win[1], chan_st[ch].win[2]);
      chan_st[ch].sum = chan_st[ch].sum + SUM_W'(med);
      if (chan_st[ch].mcount == MEDIAN_LAST) begin
        chan_st[ch].avg = sample_t'(chan_st[ch].sum >> AVG_SHIFT);
        chan_st[ch].sum = '0;
        chan_st[ch].mcount = '0;
        n_averages++;
      end else begin
        chan_st[ch].mcount = chan_st[ch].mcount + 2'd1;
      end
    end else begin
      chan_st[ch].fill = chan_st[ch].fill + 2'd1;
    end
  endfunction

  function automatic void predict_vitals(reading_t r);
    vitals_t     v;
    int unsigned wsum;
    feed_channel(CH_SYS, r.sys);
    feed_channel(CH_DIA, r.dia);
    wsum = 2 * chan_st[CH_DIA].avg + chan_st[CH_SYS].avg;
    v.sys_avg = chan_st[CH_SYS].avg;
    v.dia_avg = chan_st[CH_DIA].avg;
    v.mean = sample_t'(wsum / 3);
    if (r.hr == 0 && r.spo2 == 0) begin
      v.mean = '0;
      n_no_subject++;
    end
    vitals_due.push_back(v);
    n_items++;
  endfunction

  function automatic void check_field(string name, sample_t exp_v, sample_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // input driver
  always @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      predict_vitals(cur_item);
    end
    if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        gap_left = next_gap();
      end
      if (gap_left != 0 || pending.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        cur_item = pending.pop_front();
        in_valid <= 1'b1;
        sys_in <= cur_item.sys;
        dia_in <= cur_item.dia;
        hr_in <= cur_item.hr;
        spo2_in <= cur_item.spo2;
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i) begin
    vitals_t v;
    if (rst_ni && out_valid && !out_stall) begin
      if (vitals_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual mean %0d avg %0d/%0d",
                 $time, mean_out, sys_avg_out, dia_avg_out);
        errors++;
      end else begin
        v = vitals_due.pop_front();
        check_field("mean_pressure", v.mean, mean_out);
        check_field("systolic_average", v.sys_avg, sys_avg_out);
        check_field("diastolic_average", v.dia_avg, dia_avg_out);
        n_checked++;
      end
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = next_gap();
    end
  end

  task automatic add_item(sample_t s, sample_t d, sample_t h, sample_t o);
    reading_t r;
    r.sys = s;
    r.dia = d;
    r.hr = h;
    r.spo2 = o;
    pending.push_back(r);
  endtask

  // sender holds off until every result is back
  task automatic wait_idle();
    while (pending.size() != 0 || in_valid || vitals_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, sample_t val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_SYS_LOW:  lim_lo[CH_SYS] = val;
      REG_SYS_HIGH: lim_hi[CH_SYS] = val;
      REG_DIA_LOW:  lim_lo[CH_DIA] = val;
      REG_DIA_HIGH: lim_hi[CH_DIA] = val;
      default: ;
    endcase
  endtask

  task automatic set_bounds(sample_t sl, sample_t sh, sample_t dl, sample_t dh);
    write_reg(REG_SYS_LOW, sl);
    write_reg(REG_SYS_HIGH, sh);
    write_reg(REG_DIA_LOW, dl);
    write_reg(REG_DIA_HIGH, dh);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // mostly in range so windows fill, otherwise edges and noise
  function automatic sample_t pick_reading(int ch);
    sample_t lo_v;
    sample_t hi_v;
    lo_v = lim_lo[ch];
    hi_v = lim_hi[ch];
    if (lo_v <= hi_v && $urandom_range(0, 99) < 80) return sample_t'($urandom_range(hi_v, lo_v));
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return lo_v;
      3: return hi_v;
      4: return lo_v - 8'd1;
      default: return sample_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic sample_t pick_vital();
    if ($urandom_range(0, 9) == 0) return '0;
    return sample_t'($urandom_range(0, 255));
  endfunction

  initial begin
    sample_t sl;
    sample_t sh;
    sample_t dl;
    sample_t dh;
    lim_lo[CH_SYS] = SYS_LOW_RST;
    lim_hi[CH_SYS] = SYS_HIGH_RST;
    lim_lo[CH_DIA] = DIA_LOW_RST;
    lim_hi[CH_DIA] = DIA_HIGH_RST;
    for (int c = 0; c < 2; c++) begin
      chan_st[c] = '{win: '{default: '0}, fill: '0, mcount: '0, sum: '0, avg: '0};
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on the reset bounds
    calm = 1'b1;
    add_item(8'd0, 8'd0, 8'd0, 8'd0);
    add_item(8'd255, 8'd255, 8'd255, 8'd255);
    add_item(8'd99, 8'd69, 8'd72, 8'd98);
    add_item(8'd141, 8'd101, 8'd72, 8'd98);
    add_item(8'd100, 8'd70, 8'd60, 8'd97);
    add_item(8'd140, 8'd100, 8'd61, 8'd96);
    add_item(8'd120, 8'd85, 8'd62, 8'd95);
    // nine more accepted readings complete the first average
    for (int k = 0; k < 9; k++) begin
      add_item(sample_t'(104 + 4 * k), sample_t'(72 + 3 * k), 8'd170, 8'd85);
    end
    add_item(8'd120, 8'd85, 8'd0, 8'd0);
    add_item(8'd120, 8'd85, 8'd0, 8'd95);
    add_item(8'd120, 8'd85, 8'd80, 8'd0);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin sl = 8'd0;   sh = 8'd255; dl = 8'd0;  dh = 8'd255; end
        1: begin sl = 8'd255; sh = 8'd255; dl = 8'd255; dh = 8'd255; end
        2: begin sl = 8'd200; sh = 8'd50;  dl = 8'd60; dh = 8'd90;  end
        3: begin sl = 8'd0;   sh = 8'd0;   dl = 8'd0;  dh = 8'd0;   end
        4: begin
          sl = sample_t'($urandom_range(0, 200));
          sh = sample_t'($urandom_range(255, sl));
          dl = sample_t'($urandom_range(0, 200));
          dh = sample_t'($urandom_range(255, dl));
        end
        default: begin sl = 8'd90; sh = 8'd160; dl = 8'd50; dh = 8'd110; end
      endcase
      set_bounds(sl, sh, dl, dh);
      calm = (ph == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 14) == 0) begin
          add_item(pick_reading(CH_SYS), pick_reading(CH_DIA), 8'd0, 8'd0);
        end else begin
          add_item(pick_reading(CH_SYS), pick_reading(CH_DIA), pick_vital(), pick_vital());
        end
      end
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    $display("%0d items over %0d range settings, %0d results checked",
             n_items, NUM_PHASES + 1, n_checked);
    $display("%0d readings out of range, %0d channel averages formed, %0d with no subject",
             n_rejected, n_averages, n_no_subject);
    if (errors == 0) begin
      $display("blood_pressure_median_average regression: pass");
    end else begin
      $display("blood_pressure_median_average regression: fail");
    end
    $finish;
  end

endmodule
